FILE: hdl/wasd_pkg.sv
// Package for the wrapped-angle stencil derivative block.
// Holds shared widths, default parameter values and register index codes.
// No dependencies.
package wasd_pkg;

    localparam int ANGLE_BITS_DEFAULT     = 16;
    localparam int COEF_FRAC_BITS_DEFAULT = 12;
    localparam int NUM_TAPS               = 8;
    localparam int COEF_W                 = 18;
    localparam int OUT_W                  = 24;
    localparam int CFG_INDEX_W            = $clog2(NUM_TAPS);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COEF_M4,
        REG_COEF_M3,
        REG_COEF_M2,
        REG_COEF_M1,
        REG_COEF_P1,
        REG_COEF_P2,
        REG_COEF_P3,
        REG_COEF_P4
    } coef_index_t;

endpackage

FILE: hdl/wasd_if.sv
// Stream interfaces for the wrapped-angle stencil derivative block.
// Carry valid, ready and the stencil or result word; depend on wasd_pkg.
interface stencil_if #(
    parameter int ANGLE_BITS = wasd_pkg::ANGLE_BITS_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] center_angle;
    logic signed [ANGLE_BITS-1:0] neighbor_m4;
    logic signed [ANGLE_BITS-1:0] neighbor_m3;
    logic signed [ANGLE_BITS-1:0] neighbor_m2;
    logic signed [ANGLE_BITS-1:0] neighbor_m1;
    logic signed [ANGLE_BITS-1:0] neighbor_p1;
    logic signed [ANGLE_BITS-1:0] neighbor_p2;
    logic signed [ANGLE_BITS-1:0] neighbor_p3;
    logic signed [ANGLE_BITS-1:0] neighbor_p4;

    modport source (
        output valid, center_angle,
               neighbor_m4, neighbor_m3, neighbor_m2, neighbor_m1,
               neighbor_p1, neighbor_p2, neighbor_p3, neighbor_p4,
        input  ready
    );

    modport sink (
        input  valid, center_angle,
               neighbor_m4, neighbor_m3, neighbor_m2, neighbor_m1,
               neighbor_p1, neighbor_p2, neighbor_p3, neighbor_p4,
        output ready
    );
endinterface

interface result_if;
    logic                             valid;
    logic                             ready;
    logic signed [wasd_pkg::OUT_W-1:0] derivative;

    modport source (
        output valid, derivative,
        input  ready
    );

    modport sink (
        input  valid, derivative,
        output ready
    );
endinterface

FILE: hdl/wrapped_angle_stencil_derivative.sv
// Top level of the wrapped-angle stencil derivative block.
// Depends on wasd_pkg and the stream interfaces in wasd_if.sv.
//
// Takes one stencil word per cycle and returns one derivative word per
// stencil word, in order. The four register stages are the input capture,
// the eight wrap-and-multiply lanes (one 17x18 multiplier per tap), the
// eight-term adder and the floor shift with 24-bit saturation. Each stage
// advances whenever the stage after it is empty or moving, so bubbles are
// absorbed and the input side stalls only when all four stages hold words
// and the result is not taken. Coefficients are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while no word is
// in flight, which the block itself does not enforce. All reset to zero.
module wrapped_angle_stencil_derivative #(
    parameter int ANGLE_BITS     = wasd_pkg::ANGLE_BITS_DEFAULT,
    parameter int COEF_FRAC_BITS = wasd_pkg::COEF_FRAC_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    stencil_if.sink                           stencil,
    result_if.source                          result,
    input  logic                              cfg_we,
    input  wasd_pkg::coef_index_t             cfg_index,
    input  logic [wasd_pkg::COEF_W-1:0]       cfg_data
);
    import wasd_pkg::*;

    localparam int DIFF_W = ANGLE_BITS + 1;
    localparam int PROD_W = DIFF_W + COEF_W;
    localparam int SUM_W  = PROD_W + $clog2(NUM_TAPS);

    localparam logic signed [DIFF_W-1:0] PI     = {2'b01, {(ANGLE_BITS-1){1'b0}}};
    localparam logic signed [DIFF_W-1:0] NEG_PI = {2'b11, {(ANGLE_BITS-1){1'b0}}};
    localparam logic signed [DIFF_W-1:0] TWO_PI = {1'b1, {ANGLE_BITS{1'b0}}};
    localparam logic signed [OUT_W-1:0]  OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0]  OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    logic signed [COEF_W-1:0]     coef_reg [NUM_TAPS];

    logic                         s0_valid_reg;
    logic signed [ANGLE_BITS-1:0] ctr_reg;
    logic signed [ANGLE_BITS-1:0] nb_reg [NUM_TAPS];

    logic                         s1_valid_reg;
    logic signed [PROD_W-1:0]     prod_reg [NUM_TAPS];
    logic signed [PROD_W-1:0]     prod_next [NUM_TAPS];
    logic signed [DIFF_W-1:0]     diff [NUM_TAPS];
    logic signed [DIFF_W-1:0]     wrapped [NUM_TAPS];

    logic                         s2_valid_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [SUM_W-1:0]      sum_next;

    logic                         s3_valid_reg;
    logic signed [OUT_W-1:0]      deriv_reg;
    logic signed [OUT_W-1:0]      deriv_next;
    logic signed [SUM_W-1:0]      shifted;

    logic s0_en, s1_en, s2_en, s3_en;

    assign s3_en = !s3_valid_reg || result.ready;
    assign s2_en = !s2_valid_reg || s3_en;
    assign s1_en = !s1_valid_reg || s2_en;
    assign s0_en = !s0_valid_reg || s1_en;

    assign stencil.ready     = s0_en;
    assign result.valid      = s3_valid_reg;
    assign result.derivative = deriv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TAPS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            coef_reg[cfg_index] <= $signed(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_en)
            begin
                s0_valid_reg <= stencil.valid;
            end
            if (s1_en)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_en)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_en && stencil.valid)
        begin
            ctr_reg    <= stencil.center_angle;
            nb_reg[0]  <= stencil.neighbor_m4;
            nb_reg[1]  <= stencil.neighbor_m3;
            nb_reg[2]  <= stencil.neighbor_m2;
            nb_reg[3]  <= stencil.neighbor_m1;
            nb_reg[4]  <= stencil.neighbor_p1;
            nb_reg[5]  <= stencil.neighbor_p2;
            nb_reg[6]  <= stencil.neighbor_p3;
            nb_reg[7]  <= stencil.neighbor_p4;
        end
        if (s1_en && s0_valid_reg)
        begin
            prod_reg <= prod_next;
        end
        if (s2_en && s1_valid_reg)
        begin
            sum_reg <= sum_next;
        end
        if (s3_en && s2_valid_reg)
        begin
            deriv_reg <= deriv_next;
        end
    end

    // wrap each difference into [-pi, pi] by one turn, then weight it
    always_comb
    begin
        for (int i = 0; i < NUM_TAPS; i++)
        begin
            diff[i] = DIFF_W'(nb_reg[i]) - DIFF_W'(ctr_reg);
            if (diff[i] > PI)
            begin
                wrapped[i] = diff[i] - TWO_PI;
            end
            else if (diff[i] < NEG_PI)
            begin
                wrapped[i] = diff[i] + TWO_PI;
            end
            else
            begin
                wrapped[i] = diff[i];
            end
            prod_next[i] = wrapped[i] * coef_reg[i];
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NUM_TAPS; i++)
        begin
            sum_next = sum_next + SUM_W'(prod_reg[i]);
        end
    end

    // floor shift, then clamp to the output range
    always_comb
    begin
        shifted = sum_reg >>> COEF_FRAC_BITS;
        if ((&shifted[SUM_W-1:OUT_W-1]) || !(|shifted[SUM_W-1:OUT_W-1]))
        begin
            deriv_next = shifted[OUT_W-1:0];
        end
        else if (shifted[SUM_W-1])
        begin
            deriv_next = OUT_MIN;
        end
        else
        begin
            deriv_next = OUT_MAX;
        end
    end

endmodule

FILE: hdl/wasd_checker.sv
// Port-level checker for the wrapped-angle stencil derivative block.
// Bound to wrapped_angle_stencil_derivative; depends on its ports and on wasd_pkg.
module wasd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [wasd_pkg::OUT_W-1:0]        derivative
);
    logic [2:0] pending_reg;
    logic [2:0] pending_next;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_valid && in_ready)
        begin
            pending_next = pending_next + 3'd1;
        end
        if (out_valid && out_ready)
        begin
            pending_next = pending_next - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // hold a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(derivative))
        else $error("stalled result word changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a result stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result word without an accepted stencil word");

    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("more words in flight than pipeline stages");

endmodule

bind wrapped_angle_stencil_derivative wasd_checker u_wasd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (stencil.valid),
    .in_ready   (stencil.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .derivative (result.derivative)
);

FILE: tb/testbench.sv
// Testbench for wrapped_angle_stencil_derivative: directed wrap, floor and clamp cases,
// then random stencil words over several coefficient sets, with random gaps and stalls.
// Depends on wasd_pkg, stencil_if and result_if from the hdl folder.
module testbench;

    import wasd_pkg::*;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     WORDS_PER_SET  = 80;
    localparam int     RANDOM_SETS    = 5;
    localparam longint HALF_TURN      = longint'(1) << (ANGLE_BITS_DEFAULT - 1);
    localparam longint OUT_MAX        = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint OUT_MIN        = -(longint'(1) << (OUT_W - 1));
    localparam int     COEF_MAX       = (1 << (COEF_W - 1)) - 1;
    localparam int     COEF_MIN       = -(1 << (COEF_W - 1));

    typedef logic signed [ANGLE_BITS_DEFAULT-1:0] angle_t;
    typedef logic signed [COEF_W-1:0]             coef_t;
    typedef logic signed [OUT_W-1:0]              deriv_t;
    typedef coef_t                                coef_set_t [NUM_TAPS];

    // Taps in register order: -4, -3, -2, -1, +1, +2, +3, +4.
    typedef struct {
        angle_t center;
        angle_t nb [NUM_TAPS];
    } stencil_word_t;

    class derivative_scoreboard;
        coef_t  coef [NUM_TAPS];
        deriv_t pending [$];
        int     errors;

        function new();
            foreach (coef[i])
                coef[i] = '0;
            errors = 0;
        endfunction

        function void set_coef(int idx, coef_t val);
            coef[idx] = val;
        endfunction

        function void note_stencil(stencil_word_t w);
            longint acc;
            longint d;
            longint r;
            acc = 0;
            for (int i = 0; i < NUM_TAPS; i++)
            begin
                d = longint'(w.nb[i]) - longint'(w.center);
                if (d > HALF_TURN)
                    d = d - 2 * HALF_TURN;
                else if (d < -HALF_TURN)
                    d = d + 2 * HALF_TURN;
                acc += longint'(coef[i]) * d;
            end
            r = acc >>> COEF_FRAC_BITS_DEFAULT;
            if (r > OUT_MAX)
                r = OUT_MAX;
            else if (r < OUT_MIN)
                r = OUT_MIN;
            pending.push_back(deriv_t'(r));
        endfunction

        function void check_result(deriv_t got);
            deriv_t want;
            if (pending.size() == 0)
            begin
                $error("derivative: word with none pending, actual %0d", got);
                errors++;
            end
            else
            begin
                want = pending.pop_front();
                if (got !== want)
                begin
                    $error("derivative: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    coef_index_t         cfg_index;
    logic [COEF_W-1:0]   cfg_data;
    logic                rx_ready  = 1'b0;
    logic                rx_steady = 1'b0;
    int                  rx_hold   = 0;
    bit                  tx_steady = 1'b0;
    int                  idle_cycles = 0;
    derivative_scoreboard sb;

    stencil_if #(.ANGLE_BITS(ANGLE_BITS_DEFAULT)) stencil_ch ();
    result_if                                     result_ch ();

    assign result_ch.ready = rx_ready;

    wrapped_angle_stencil_derivative i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .stencil   (stencil_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rx_hold != 0)
            rx_hold <= rx_hold - 1;
        else if (rx_steady)
            rx_ready <= 1'b1;
        else if ($urandom_range(0, 9) < 6)
        begin
            rx_ready <= 1'b1;
            rx_hold  <= $urandom_range(0, 15);
        end
        else if ($urandom_range(0, 9) < 8)
        begin
            rx_ready <= 1'b0;
            rx_hold  <= $urandom_range(0, 3);
        end
        else
        begin
            rx_ready <= 1'b0;
            rx_hold  <= $urandom_range(10, 40);
        end
    end

    always @(posedge clk)
    begin : monitor
        stencil_word_t seen;
        if (rst_n)
        begin
            if (stencil_ch.valid && stencil_ch.ready)
            begin
                seen.center = stencil_ch.center_angle;
                seen.nb[0]  = stencil_ch.neighbor_m4;
                seen.nb[1]  = stencil_ch.neighbor_m3;
                seen.nb[2]  = stencil_ch.neighbor_m2;
                seen.nb[3]  = stencil_ch.neighbor_m1;
                seen.nb[4]  = stencil_ch.neighbor_p1;
                seen.nb[5]  = stencil_ch.neighbor_p2;
                seen.nb[6]  = stencil_ch.neighbor_p3;
                seen.nb[7]  = stencil_ch.neighbor_p4;
                sb.note_stencil(seen);
            end
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.derivative);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (stencil_ch.valid && stencil_ch.ready)
                   || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic stencil_word_t uniform_word(int c, int n);
        stencil_word_t w;
        w.center = angle_t'(c);
        foreach (w.nb[i])
            w.nb[i] = angle_t'(n);
        return w;
    endfunction

    function automatic stencil_word_t random_word();
        stencil_word_t w;
        int kind;
        int slope;
        int off;
        kind   = $urandom_range(0, 9);
        slope  = int'($urandom_range(0, 16000)) - 8000;
        w.center = angle_t'($urandom);
        foreach (w.nb[i])
        begin
            off = (i < 4) ? i - 4 : i - 3;
            if (kind < 4)
                w.nb[i] = angle_t'($urandom);
            else if (kind < 8)
                w.nb[i] = angle_t'(int'(w.center) + slope * off
                                   + int'($urandom_range(0, 64)) - 32);
            else
                w.nb[i] = angle_t'(int'(w.center) + 32768
                                   + int'($urandom_range(0, 4)) - 2);
        end
        return w;
    endfunction

    function automatic coef_t random_coef();
        case ($urandom_range(0, 5))
            0: return coef_t'(COEF_MIN);
            1: return coef_t'(COEF_MAX);
            2: return '0;
            3: return $urandom_range(0, 1) ? coef_t'(1) : coef_t'(-1);
            default: return coef_t'($urandom);
        endcase
    endfunction

    task automatic send_stencil(input stencil_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            stencil_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stencil_ch.center_angle <= w.center;
        stencil_ch.neighbor_m4  <= w.nb[0];
        stencil_ch.neighbor_m3  <= w.nb[1];
        stencil_ch.neighbor_m2  <= w.nb[2];
        stencil_ch.neighbor_m1  <= w.nb[3];
        stencil_ch.neighbor_p1  <= w.nb[4];
        stencil_ch.neighbor_p2  <= w.nb[5];
        stencil_ch.neighbor_p3  <= w.nb[6];
        stencil_ch.neighbor_p4  <= w.nb[7];
        stencil_ch.valid        <= 1'b1;
        @(posedge clk);
        while (!stencil_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid and hold until every pending derivative has come back.
    task automatic wait_drained();
        stencil_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_coefs(input coef_set_t vals);
        coef_index_t idx;
        idx = idx.first();
        for (int i = 0; i < NUM_TAPS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_coef(i, vals[i]);
            idx = idx.next();
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        stencil_word_t w;
        coef_set_t     cs;
        sb = new();
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_index               <= REG_COEF_M4;
        cfg_data                <= '0;
        stencil_ch.valid        <= 1'b0;
        stencil_ch.center_angle <= '0;
        stencil_ch.neighbor_m4  <= '0;
        stencil_ch.neighbor_m3  <= '0;
        stencil_ch.neighbor_m2  <= '0;
        stencil_ch.neighbor_m1  <= '0;
        stencil_ch.neighbor_p1  <= '0;
        stencil_ch.neighbor_p2  <= '0;
        stencil_ch.neighbor_p3  <= '0;
        stencil_ch.neighbor_p4  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coefficients still at reset
        send_stencil(uniform_word(-32768, 32767));
        send_stencil(random_word());
        wait_drained();

        // eighth-order first derivative
        load_coefs('{15, -156, 819, -3277, 3277, -819, 156, -15});
        send_stencil(uniform_word(0, 0));
        send_stencil(uniform_word(-32768, 32767));
        send_stencil(uniform_word(32767, -32768));
        send_stencil(uniform_word(-16384, 16384));
        send_stencil(uniform_word(16384, -16384));
        send_stencil(uniform_word(-16384, 16385));
        send_stencil(uniform_word(16383, -16386));
        w = uniform_word(0, 32767);
        for (int i = 0; i < NUM_TAPS; i += 2)
            w.nb[i] = angle_t'(-32768);
        send_stencil(w);
        w = uniform_word(30000, 0);
        for (int i = 0; i < NUM_TAPS; i++)
            w.nb[i] = angle_t'(30000 + 1000 * ((i < 4) ? i - 4 : i - 3));
        send_stencil(w);
        wait_drained();

        // floor rounding on a single unit tap
        load_coefs('{0, 0, 0, 0, 1, 0, 0, 0});
        send_stencil(uniform_word(0, -1));
        send_stencil(uniform_word(0, 1));
        wait_drained();

        // clamp and range limits
        load_coefs('{default: coef_t'(COEF_MIN)});
        send_stencil(uniform_word(16384, -16384));
        send_stencil(uniform_word(-16384, 16384));
        wait_drained();
        load_coefs('{default: coef_t'(COEF_MAX)});
        send_stencil(uniform_word(-16384, 16384));
        send_stencil(uniform_word(16384, -16384));
        wait_drained();

        for (int s = 0; s < RANDOM_SETS; s++)
        begin
            foreach (cs[i])
                cs[i] = random_coef();
            load_coefs(cs);
            tx_steady = (s == 2);
            rx_steady <= (s == 2);
            for (int n = 0; n < WORDS_PER_SET; n++)
            begin
                send_stencil(random_word());
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
